[design/perlin_noise_2d_macros.svh]
// Assertion macros for the perlin_noise_2d checker.
// Expects clk and arst_n in the scope of each use.
`ifndef PERLIN_NOISE_2D_MACROS_SVH
`define PERLIN_NOISE_2D_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PN2D_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Signal holds its value for the cycle after cond.
`define PN2D_HOLD(label, cond, sig, msg) \
	`PN2D_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

[design/pn2d_pkg.sv]
// Shared types, constants and arithmetic helpers for perlin_noise_2d.
// No dependencies.
`default_nettype none
package pn2d_pkg;
	localparam int TABLE_SIZE = 256;
	localparam int FRAC_BITS  = 16;
	localparam int TAB_AW     = $clog2(TABLE_SIZE);
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);

	typedef enum logic {
		OP_EVAL  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [7:0]  table_index;
		logic [7:0]  table_value;
	} item_t;

	// floor(p / 256) saturated to signed 32 bits
	function automatic logic signed [31:0] scale_sat(input logic signed [48:0] p);
		logic signed [40:0] s;
		s = 41'(p >>> 8);
		if (s > 41'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -41'sd2147483648)
			return 32'sh80000000;
		else
			return s[31:0];
	endfunction

	// dot product with one of the eight fixed gradients
	function automatic logic signed [18:0] grad_dot(input logic [2:0] g,
		input logic signed [17:0] dx, input logic signed [17:0] dy);
		logic signed [18:0] x;
		logic signed [18:0] y;
		logic signed [18:0] r;
		x = 19'(dx);
		y = 19'(dy);
		unique case (g)
			3'd0: r = x + y;
			3'd1: r = y - x;
			3'd2: r = x - y;
			3'd3: r = -x - y;
			3'd4: r = x;
			3'd5: r = -x;
			3'd6: r = y;
			default: r = -y;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

[design/pn2d_queue.sv]
// Front part: accepts items and holds them in a short queue for the back part.
// Depends on pn2d_pkg.
`default_nettype none
module pn2d_queue import pn2d_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_stall,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop,
	output item_t      pop_item
);
	item_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q;
	logic [QAW-1:0]   rptr_q;
	logic [QAW:0]     cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_stall = (cnt_q == (QAW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rptr_q];
	assign do_push    = push_valid & ~push_stall;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

[design/pn2d_mem.sv]
// One copy of the permutation table: one write port, one registered read port.
// Depends on pn2d_pkg.
`default_nettype none
module pn2d_mem import pn2d_pkg::*; (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [TAB_AW-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic              re,
	input  wire logic [TAB_AW-1:0] raddr,
	output logic [7:0]             rdata
);
	logic [7:0] ram_q [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (we)
			ram_q[waddr] <= wdata;
		if (re)
			rdata <= ram_q[raddr];
	end
endmodule
`default_nettype wire

[design/pn2d_core.sv]
// Back part: scaling, table hashing, fade and blend pipeline.
// Depends on pn2d_pkg and pn2d_mem.
`default_nettype none
module pn2d_core import pn2d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	input  wire logic [15:0] coord_scale,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      noise_value
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	op_t                 op_s1, op_s2;
	logic signed [48:0]  px_s1, py_s1;
	logic [7:0]          idx_s1, idx_s2, val_s1, val_s2;
	logic signed [31:0]  sx_s2, sy_s2;
	logic [TAB_AW-1:0]   ix_s3;
	logic [15:0]         fx_s3, fy_s3, fx_s4, fy_s4;
	logic [15:0]         t2x_s4, t2y_s4;
	logic [19:0]         inx_s4, iny_s4;
	logic [15:0]         t3x_s5, t3y_s5;
	logic [19:0]         kx_s5, ky_s5;
	logic signed [18:0]  a_s5, b_s5, c_s5, d_s5, a_s6, b_s6, c_s6, d_s6;
	logic [19:0]         ux_s6, uy_s6, uy_s7;
	logic signed [23:0]  l1_s7, l2_s7;
	logic [15:0]         noise_s8;

	logic                wr_en;
	logic [7:0]          h0, h1;
	logic [7:0]          g0, g1, g2, g3;
	logic [TAB_AW-1:0]   iy2, ix3p;

	assign en        = ~(v_s8 & out_stall);
	assign q_pop     = q_valid & en;
	assign out_valid = v_s8;
	assign noise_value = noise_s8;
	assign wr_en     = en & v_s2 & (op_s2 == OP_WRITE);
	assign iy2       = sy_s2[FRAC_BITS +: TAB_AW];
	assign ix3p      = ix_s3 + 1'b1;

	pn2d_mem u_ma0 (.clk, .we(wr_en), .waddr(idx_s2), .wdata(val_s2), .re(en),
		.raddr(iy2), .rdata(h0));
	pn2d_mem u_ma1 (.clk, .we(wr_en), .waddr(idx_s2), .wdata(val_s2), .re(en),
		.raddr(iy2 + 1'b1), .rdata(h1));
	pn2d_mem u_mb0 (.clk, .we(wr_en), .waddr(idx_s2), .wdata(val_s2), .re(en),
		.raddr(ix_s3 + h0), .rdata(g0));
	pn2d_mem u_mb1 (.clk, .we(wr_en), .waddr(idx_s2), .wdata(val_s2), .re(en),
		.raddr(ix3p + h0), .rdata(g1));
	pn2d_mem u_mb2 (.clk, .we(wr_en), .waddr(idx_s2), .wdata(val_s2), .re(en),
		.raddr(ix_s3 + h1), .rdata(g2));
	pn2d_mem u_mb3 (.clk, .we(wr_en), .waddr(idx_s2), .wdata(val_s2), .re(en),
		.raddr(ix3p + h1), .rdata(g3));

	// fade pieces
	logic [31:0] sqx, sqy, cbx, cby;
	logic [35:0] ipx, ipy, fdx, fdy;
	assign sqx = 32'(fx_s3) * 32'(fx_s3);
	assign sqy = 32'(fy_s3) * 32'(fy_s3);
	assign ipx = 36'(fx_s3) * 36'(20'd983040 - 20'(fx_s3) * 20'd6);
	assign ipy = 36'(fy_s3) * 36'(20'd983040 - 20'(fy_s3) * 20'd6);
	assign cbx = 32'(t2x_s4) * 32'(fx_s4);
	assign cby = 32'(t2y_s4) * 32'(fy_s4);
	assign fdx = 36'(t3x_s5) * 36'(kx_s5);
	assign fdy = 36'(t3y_s5) * 36'(ky_s5);

	// corner offsets
	logic signed [17:0] ox0, ox1, oy0, oy1;
	assign ox0 = 18'(fx_s4);
	assign oy0 = 18'(fy_s4);
	assign ox1 = 18'(fx_s4) - 18'sd65536;
	assign oy1 = 18'(fy_s4) - 18'sd65536;

	// blends
	logic signed [40:0] pab, pcd;
	logic signed [45:0] pl;
	logic signed [25:0] r7;
	logic signed [23:0] rq;
	logic signed [24:0] dl;
	assign pab = 41'($signed({1'b0, ux_s6})) * 41'(20'(b_s6) - 20'(a_s6));
	assign pcd = 41'($signed({1'b0, ux_s6})) * 41'(20'(d_s6) - 20'(c_s6));
	assign dl  = 25'(l2_s7) - 25'(l1_s7);
	assign pl  = 46'($signed({1'b0, uy_s7})) * 46'(dl);
	assign r7  = 26'(l1_s7) + 26'(pl >>> 16);
	assign rq  = 24'(r7 >>> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2 & (op_s2 == OP_EVAL);
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= q_item.opcode;
			idx_s1 <= q_item.table_index;
			val_s1 <= q_item.table_value;
			px_s1  <= 49'($signed(q_item.coord_x)) * 49'($signed({1'b0, coord_scale}));
			py_s1  <= 49'($signed(q_item.coord_y)) * 49'($signed({1'b0, coord_scale}));

			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			sx_s2  <= scale_sat(px_s1);
			sy_s2  <= scale_sat(py_s1);

			ix_s3  <= sx_s2[FRAC_BITS +: TAB_AW];
			fx_s3  <= sx_s2[FRAC_BITS-1 -: 16];
			fy_s3  <= sy_s2[FRAC_BITS-1 -: 16];

			fx_s4  <= fx_s3;
			fy_s4  <= fy_s3;
			t2x_s4 <= sqx[31:16];
			t2y_s4 <= sqy[31:16];
			inx_s4 <= ipx[35:16];
			iny_s4 <= ipy[35:16];

			t3x_s5 <= cbx[31:16];
			t3y_s5 <= cby[31:16];
			kx_s5  <= 20'd655360 - inx_s4;
			ky_s5  <= 20'd655360 - iny_s4;
			a_s5   <= grad_dot(g0[2:0], ox0, oy0);
			b_s5   <= grad_dot(g1[2:0], ox1, oy0);
			c_s5   <= grad_dot(g2[2:0], ox0, oy1);
			d_s5   <= grad_dot(g3[2:0], ox1, oy1);

			ux_s6  <= fdx[35:16];
			uy_s6  <= fdy[35:16];
			a_s6   <= a_s5;
			b_s6   <= b_s5;
			c_s6   <= c_s5;
			d_s6   <= d_s5;

			l1_s7  <= 24'(a_s6) + 24'(pab >>> 16);
			l2_s7  <= 24'(c_s6) + 24'(pcd >>> 16);
			uy_s7  <= uy_s6;

			if (rq > 24'sd32767)
				noise_s8 <= 16'h7fff;
			else if (rq < -24'sd32768)
				noise_s8 <= 16'h8000;
			else
				noise_s8 <= rq[15:0];
		end
	end
endmodule
`default_nettype wire

[design/perlin_noise_2d.sv]
// Top level of the 2D gradient noise block: input queue, noise pipeline, scale register.
// Depends on pn2d_pkg, pn2d_queue, pn2d_core.
`default_nettype none
// One item per clock sustained while out_stall is low; an evaluate's result goes from the
// queue through the s1 to s8 pipeline registers to noise_value. The rate is
// held by six copies of the permutation table, two read for the row hash and four for the
// corner hash. Table writes go in order with evaluates through the same queue; load every
// entry an evaluate can reach before evaluating.
module perlin_noise_2d import pn2d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic [7:0]  table_index,
	input  wire logic [7:0]  table_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      noise_value,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);
	logic [15:0] coord_scale_q;
	item_t       in_item;
	item_t       q_item;
	logic        q_valid;
	logic        q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			coord_scale_q <= 16'd256;
		else if (cfg_we)
			coord_scale_q <= cfg_wdata;
	end

	assign in_item = '{opcode: op_t'(opcode), coord_x: coord_x, coord_y: coord_y,
		table_index: table_index, table_value: table_value};

	pn2d_queue u_queue (
		.clk, .arst_n,
		.push_valid(in_valid), .push_stall(in_stall), .push_item(in_item),
		.pop_valid(q_valid), .pop(q_pop), .pop_item(q_item)
	);

	pn2d_core u_core (
		.clk, .arst_n,
		.q_valid, .q_item, .q_pop,
		.coord_scale(coord_scale_q),
		.out_valid, .out_stall, .noise_value
	);
endmodule
`default_nettype wire

[design/pn2d_checker.sv]
// Port-level checker for perlin_noise_2d, bound to the top level.
// Depends on perlin_noise_2d_macros.svh.
`default_nettype none
`include "perlin_noise_2d_macros.svh"
module pn2d_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] noise_value
);
	`PN2D_HOLD(a_out_valid_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
	`PN2D_HOLD(a_noise_hold, out_valid && out_stall, noise_value, "noise_value changed while stalled")
	// queue can only fill while the output is held
	`PN2D_ASSERT(a_no_stall_when_flowing, !(out_valid && out_stall) |=> !in_stall, "input stalled while back end flowing")
endmodule

bind perlin_noise_2d pn2d_checker u_pn2d_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .noise_value
);
`default_nettype wire
